[rtl/rvx_pkg.sv]
// Shared constants, opcodes and the data memory request type of the execute unit.
package rvx_pkg;

  localparam int REG_COUNT = 32;
  localparam int RF_AW     = $clog2(REG_COUNT);
  localparam int DATA_W    = 32;
  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int LANES     = 4;
  localparam int LANE_SW   = $clog2(LANES);
  localparam int ROW_AW    = MEM_AW - LANE_SW;
  localparam int ROWS      = MEM_BYTES / LANES;

  localparam logic [7:0] OP_NOP = 8'd0;
  localparam logic [7:0] OP_ADD = 8'd1;
  localparam logic [7:0] OP_SUB = 8'd2;
  localparam logic [7:0] OP_AND = 8'd3;
  localparam logic [7:0] OP_OR  = 8'd4;
  localparam logic [7:0] OP_XOR = 8'd5;
  localparam logic [7:0] OP_NOT = 8'd6;
  localparam logic [7:0] OP_LSH = 8'd7;
  localparam logic [7:0] OP_ASH = 8'd8;
  localparam logic [7:0] OP_TCU = 8'd9;
  localparam logic [7:0] OP_TCS = 8'd10;
  localparam logic [7:0] OP_SET = 8'd11;
  localparam logic [7:0] OP_MOV = 8'd12;
  localparam logic [7:0] OP_LDW = 8'd13;
  localparam logic [7:0] OP_STW = 8'd14;
  localparam logic [7:0] OP_LDB = 8'd15;
  localparam logic [7:0] OP_STB = 8'd16;

  // One data memory access, issued as an item leaves the operand stage.
  typedef struct packed {
    logic              ld;
    logic              st;
    logic              byte_op;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } dm_req_t;

endpackage

[rtl/rvx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rvx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/rvx_regfile.sv]
// Register file: two mirrored RAM banks for two read ports, valid bits for reset-to-zero.
module rvx_regfile (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       rd_en,
  input  logic [rvx_pkg::RF_AW-1:0]  rd_idx0,
  input  logic [rvx_pkg::RF_AW-1:0]  rd_idx1,
  output logic [rvx_pkg::DATA_W-1:0] rd_data0,
  output logic [rvx_pkg::DATA_W-1:0] rd_data1,
  input  logic                       wr_en,
  input  logic [rvx_pkg::RF_AW-1:0]  wr_idx,
  input  logic [rvx_pkg::DATA_W-1:0] wr_data
);

  logic [rvx_pkg::REG_COUNT-1:0] valid_r;
  logic                          vq0_r;
  logic                          vq1_r;
  logic [rvx_pkg::DATA_W-1:0]    q0;
  logic [rvx_pkg::DATA_W-1:0]    q1;

  rvx_ram #(.WIDTH(rvx_pkg::DATA_W), .DEPTH(rvx_pkg::REG_COUNT)) u_bank0 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx0),
    .rdata (q0)
  );

  rvx_ram #(.WIDTH(rvx_pkg::DATA_W), .DEPTH(rvx_pkg::REG_COUNT)) u_bank1 (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_idx1),
    .rdata (q1)
  );

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vq0_r   <= 1'b0;
      vq1_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        vq0_r <= valid_r[rd_idx0];
        vq1_r <= valid_r[rd_idx1];
      end
    end
  end

  assign rd_data0 = vq0_r ? q0 : '0;
  assign rd_data1 = vq1_r ? q1 : '0;

endmodule

[rtl/rvx_dmem.sv]
// Byte-addressed data memory as four byte lanes; little-endian word and byte access.
module rvx_dmem (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rvx_pkg::dm_req_t           req,
  output logic [rvx_pkg::DATA_W-1:0] rd_word
);

  logic [rvx_pkg::LANE_SW-1:0] rot_r;
  logic [7:0]                  lane_q [rvx_pkg::LANES];

  for (genvar L = 0; L < rvx_pkg::LANES; L++) begin : g_lane
    logic [rvx_pkg::LANE_SW-1:0] off;
    logic [rvx_pkg::MEM_AW-1:0]  baddr;
    logic                        we;

    // Byte number within the word that falls in this lane, and its wrapped address.
    assign off   = rvx_pkg::LANE_SW'(L) - req.addr[rvx_pkg::LANE_SW-1:0];
    assign baddr = req.addr + rvx_pkg::MEM_AW'(off);
    assign we    = req.st && (!req.byte_op || (off == '0));

    rvx_ram #(.WIDTH(8), .DEPTH(rvx_pkg::ROWS)) u_lane (
      .clk   (clk),
      .we    (we),
      .waddr (baddr[rvx_pkg::MEM_AW-1:rvx_pkg::LANE_SW]),
      .wdata (req.wdata[8*off +: 8]),
      .re    (req.ld),
      .raddr (baddr[rvx_pkg::MEM_AW-1:rvx_pkg::LANE_SW]),
      .rdata (lane_q[L])
    );
  end

  // Hold the start lane of the last load to rotate the lanes back into byte order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r <= '0;
    end else if (req.ld) begin
      rot_r <= req.addr[rvx_pkg::LANE_SW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < rvx_pkg::LANES; i++) begin
      rd_word[8*i +: 8] = lane_q[rot_r + rvx_pkg::LANE_SW'(i)];
    end
  end

endmodule

[rtl/register_vm_execute_unit_top.sv]
// Execute unit top: operand, memory and result stages of the register machine.
//
//  Channel | Ports          | Width | Contents (low bit first)
//  --------+----------------+-------+------------------------------------------------
//  input   | in_t*          | 40    | operation, dest_reg, src_reg_b, src_reg_c, immediate
//  result  | out_t*         | 56    | reg_written, written_reg, written_value,
//          |                |       | mem_written, mem_address, bad_opcode
//
// One instruction per cycle, sustained. Each input beat passes through the register file
// read, then the data memory read, then the result register. Reset (rst_n low, synchronous)
// empties all stages and marks every register as zero; data memory is not cleared. A
// stalled result beat holds all three stages.
module register_vm_execute_unit_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] operation, [12:8] dest_reg, [17:13] src_reg_b, [22:18] src_reg_c,
  // [38:23] immediate, [39] zero
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] reg_written, [5:1] written_reg, [37:6] written_value, [38] mem_written,
  // [50:39] mem_address, [51] bad_opcode, [55:52] zero
  output logic [55:0] out_tdata
);

  localparam int AW = rvx_pkg::RF_AW;
  localparam int DW = rvx_pkg::DATA_W;
  localparam int MW = rvx_pkg::MEM_AW;

  // Unpack the input beat.
  logic [7:0]    in_op;
  logic [AW-1:0] in_ra;
  logic [AW-1:0] in_rb;
  logic [AW-1:0] in_rc;
  logic [15:0]   in_imm;
  logic          in_is_st;
  logic [AW-1:0] in_p1idx;

  assign in_op    = in_tdata[7:0];
  assign in_ra    = in_tdata[8 +: AW];
  assign in_rb    = in_tdata[13 +: AW];
  assign in_rc    = in_tdata[18 +: AW];
  assign in_imm   = in_tdata[38:23];
  assign in_is_st = (in_op == rvx_pkg::OP_STW) || (in_op == rvx_pkg::OP_STB);
  // Second read port serves the address register of a store, else register C.
  assign in_p1idx = in_is_st ? in_ra : in_rc;

  // Whole pipe moves together whenever the result register is free or being taken.
  logic adv;
  logic out_tvalid_r;
  logic [55:0] out_tdata_r;

  assign adv        = !out_tvalid_r || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Operand stage registers.
  logic          s1_vld_r;
  logic [7:0]    s1_op_r;
  logic [AW-1:0] s1_ra_r;
  logic [AW-1:0] s1_rb_r;
  logic [AW-1:0] s1_p1idx_r;
  logic [15:0]   s1_imm_r;

  // Memory stage registers.
  logic          s2_vld_r;
  logic          s2_wr_r;
  logic [AW-1:0] s2_ra_r;
  logic [DW-1:0] s2_val_r;
  logic          s2_mw_r;
  logic [MW-1:0] s2_maddr_r;
  logic          s2_bad_r;
  logic          s2_ldw_r;
  logic          s2_ldb_r;

  // Last register write, kept for the item that read the file at that same edge.
  logic          wb_vld_r;
  logic [AW-1:0] wb_idx_r;
  logic [DW-1:0] wb_val_r;

  logic [DW-1:0] rd_data0;
  logic [DW-1:0] rd_data1;
  logic [DW-1:0] mem_word;
  logic [DW-1:0] s2_wval;
  logic          rf_we;
  rvx_pkg::dm_req_t dm_req;

  // Final value of the item in the memory stage; loads pick up the memory data here.
  always_comb begin
    priority if (s2_ldw_r) begin
      s2_wval = mem_word;
    end else if (s2_ldb_r) begin
      s2_wval = {24'd0, mem_word[7:0]};
    end else begin
      s2_wval = s2_val_r;
    end
  end

  assign rf_we = adv && s2_vld_r && s2_wr_r;

  rvx_regfile u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (adv),
    .rd_idx0  (in_rb),
    .rd_idx1  (in_p1idx),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .wr_en    (rf_we),
    .wr_idx   (s2_ra_r),
    .wr_data  (s2_wval)
  );

  // Forward the item ahead first, then the write made as this item read the file.
  logic [DW-1:0] opb;
  logic [DW-1:0] opx;

  always_comb begin
    priority if (s2_vld_r && s2_wr_r && (s2_ra_r == s1_rb_r)) begin
      opb = s2_wval;
    end else if (wb_vld_r && (wb_idx_r == s1_rb_r)) begin
      opb = wb_val_r;
    end else begin
      opb = rd_data0;
    end
    priority if (s2_vld_r && s2_wr_r && (s2_ra_r == s1_p1idx_r)) begin
      opx = s2_wval;
    end else if (wb_vld_r && (wb_idx_r == s1_p1idx_r)) begin
      opx = wb_val_r;
    end else begin
      opx = rd_data1;
    end
  end

  // Shifts: signed count, left when zero or positive, right by the magnitude otherwise.
  logic          arith;
  logic          fill;
  logic          rsh_ok;
  logic [4:0]    mag;
  logic [DW-1:0] shl;
  logic [DW-1:0] shr;
  logic [DW-1:0] sh_res;

  always_comb begin
    arith  = (s1_op_r == rvx_pkg::OP_ASH);
    fill   = arith && opb[DW-1];
    shl    = (opx[DW-1:5] == '0) ? (opb << opx[4:0]) : '0;
    rsh_ok = (&opx[DW-1:5]) && (opx[4:0] != 5'd0);
    mag    = 5'd0 - opx[4:0];
    shr    = rsh_ok ? DW'($signed({fill, opb}) >>> mag) : {DW{fill}};
    sh_res = opx[DW-1] ? shr : shl;
  end

  // Three-way compares; flip sign bits for the signed form.
  logic [DW-1:0] cmp_b;
  logic [DW-1:0] cmp_c;
  logic [DW-1:0] cmp_res;

  always_comb begin
    cmp_b = opb ^ {(s1_op_r == rvx_pkg::OP_TCS), {(DW-1){1'b0}}};
    cmp_c = opx ^ {(s1_op_r == rvx_pkg::OP_TCS), {(DW-1){1'b0}}};
    priority if (cmp_b > cmp_c) begin
      cmp_res = DW'(1);
    end else if (cmp_b < cmp_c) begin
      cmp_res = '1;
    end else begin
      cmp_res = '0;
    end
  end

  // Decode and result select.
  logic          s1_wr;
  logic [DW-1:0] s1_val;
  logic          s1_mw;
  logic          s1_bad;
  logic          s1_ldw;
  logic          s1_ldb;
  logic          s1_byte;

  always_comb begin
    s1_wr   = 1'b0;
    s1_val  = '0;
    s1_mw   = 1'b0;
    s1_bad  = 1'b0;
    s1_ldw  = 1'b0;
    s1_ldb  = 1'b0;
    s1_byte = 1'b0;
    unique case (s1_op_r)
      rvx_pkg::OP_NOP: begin
      end
      rvx_pkg::OP_ADD: begin
        s1_wr = 1'b1; s1_val = opb + opx;
      end
      rvx_pkg::OP_SUB: begin
        s1_wr = 1'b1; s1_val = opb - opx;
      end
      rvx_pkg::OP_AND: begin
        s1_wr = 1'b1; s1_val = opb & opx;
      end
      rvx_pkg::OP_OR: begin
        s1_wr = 1'b1; s1_val = opb | opx;
      end
      rvx_pkg::OP_XOR: begin
        s1_wr = 1'b1; s1_val = opb ^ opx;
      end
      rvx_pkg::OP_NOT: begin
        s1_wr = 1'b1; s1_val = ~opb;
      end
      rvx_pkg::OP_LSH, rvx_pkg::OP_ASH: begin
        s1_wr = 1'b1; s1_val = sh_res;
      end
      rvx_pkg::OP_TCU, rvx_pkg::OP_TCS: begin
        s1_wr = 1'b1; s1_val = cmp_res;
      end
      rvx_pkg::OP_SET: begin
        s1_wr = 1'b1; s1_val = {{(DW-16){s1_imm_r[15]}}, s1_imm_r};
      end
      rvx_pkg::OP_MOV: begin
        s1_wr = 1'b1; s1_val = opb;
      end
      rvx_pkg::OP_LDW: begin
        s1_wr = 1'b1; s1_ldw = 1'b1;
      end
      rvx_pkg::OP_STW: begin
        s1_mw = 1'b1;
      end
      rvx_pkg::OP_LDB: begin
        s1_wr = 1'b1; s1_ldb = 1'b1;
      end
      rvx_pkg::OP_STB: begin
        s1_mw = 1'b1; s1_byte = 1'b1;
      end
      default: begin
        s1_bad = 1'b1;
      end
    endcase
  end

  // Issue the memory access as the item leaves the operand stage; loads use B, stores A.
  always_comb begin
    dm_req.ld      = adv && s1_vld_r && (s1_ldw || s1_ldb);
    dm_req.st      = adv && s1_vld_r && s1_mw;
    dm_req.byte_op = s1_byte;
    dm_req.addr    = s1_mw ? opx[MW-1:0] : opb[MW-1:0];
    dm_req.wdata   = opb;
  end

  rvx_dmem u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dm_req),
    .rd_word (mem_word)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      wb_vld_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r     <= in_tvalid;
      s2_vld_r     <= s1_vld_r;
      wb_vld_r     <= rf_we;
      out_tvalid_r <= s2_vld_r;
    end
  end

  // Payload; advance with the pipe.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_op;
      s1_ra_r    <= in_ra;
      s1_rb_r    <= in_rb;
      s1_p1idx_r <= in_p1idx;
      s1_imm_r   <= in_imm;

      s2_wr_r    <= s1_wr;
      s2_ra_r    <= s1_wr ? s1_ra_r : '0;
      s2_val_r   <= s1_val;
      s2_mw_r    <= s1_mw;
      s2_maddr_r <= s1_mw ? opx[MW-1:0] : '0;
      s2_bad_r   <= s1_bad;
      s2_ldw_r   <= s1_ldw;
      s2_ldb_r   <= s1_ldb;

      wb_idx_r   <= s2_ra_r;
      wb_val_r   <= s2_wval;

      out_tdata_r <= {4'd0, s2_bad_r, s2_maddr_r, s2_mw_r,
                      (s2_wr_r ? s2_wval : {DW{1'b0}}), s2_ra_r, s2_wr_r};
    end
  end

`ifndef SYNTH
  // A result never writes both a register and memory.
  a_one_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[38]))
    else $error("result writes register and memory");

  // A bad opcode changes nothing.
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[51]) |-> (out_tdata[50:0] == '0))
    else $error("bad opcode result carries side effects");

  // Register writes and memory accesses happen only while the pipe advances.
  a_write_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (rf_we || dm_req.st || dm_req.ld) |-> adv)
    else $error("state change during stall");

  // An item in the memory stage reaches the result register on the next advance.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s2_vld_r) |=> out_tvalid)
    else $error("result lost between stages");
`endif

endmodule
